// ----- sv/hrlp_pkg.sv -----
// Package for the HTTP request line parser: payload structs, status and
// method codes, character constants and the method name table.
// No dependencies.
package hrlp_pkg;

  // One input byte of the request line, with the final byte flagged.
  typedef struct packed {
    logic [7:0] data_byte;
    logic       last_byte;
  } in_item_t;

  // One result: either a path byte or the final status of the line.
  typedef struct packed {
    logic       kind;
    logic [7:0] path_byte;
    logic [2:0] status;
    logic [2:0] method_code;
    logic [3:0] version_major;
    logic [3:0] version_minor;
  } out_item_t;

  // Result kinds.
  localparam logic KindPath   = 1'b0;
  localparam logic KindStatus = 1'b1;

  // Status codes; StOk also stands for "no error recorded".
  localparam logic [2:0] StOk         = 3'd0;
  localparam logic [2:0] StTooShort   = 3'd1;
  localparam logic [2:0] StBadMethod  = 3'd2;
  localparam logic [2:0] StNoSpace    = 3'd3;
  localparam logic [2:0] StBadPath    = 3'd4;
  localparam logic [2:0] StBadSig     = 3'd5;
  localparam logic [2:0] StBadVersion = 3'd6;
  localparam logic [2:0] StTooLong    = 3'd7;

  // Method codes, also the rows of the name table.
  localparam logic [2:0] MethodGet    = 3'd0;
  localparam logic [2:0] MethodPost   = 3'd1;
  localparam logic [2:0] MethodPut    = 3'd2;
  localparam logic [2:0] MethodPatch  = 3'd3;
  localparam logic [2:0] MethodDelete = 3'd4;
  localparam int unsigned NumMethods  = 5;

  // Shortest line that can be well formed.
  localparam logic [3:0] MinLine = 4'd14;

  // Characters.
  localparam logic [7:0] CharSpace    = 8'h20;
  localparam logic [7:0] CharSlash    = 8'h2F;
  localparam logic [7:0] CharQuestion = 8'h3F;
  localparam logic [7:0] CharDot      = 8'h2E;
  localparam logic [7:0] CharZero     = 8'h30;
  localparam logic [7:0] CharNine     = 8'h39;

  // Method names, padded with zeros to eight characters.
  localparam logic [7:0] NameTab [NumMethods][8] = '{
    '{8'h47, 8'h45, 8'h54, 8'h00, 8'h00, 8'h00, 8'h00, 8'h00},  // GET
    '{8'h50, 8'h4F, 8'h53, 8'h54, 8'h00, 8'h00, 8'h00, 8'h00},  // POST
    '{8'h50, 8'h55, 8'h54, 8'h00, 8'h00, 8'h00, 8'h00, 8'h00},  // PUT
    '{8'h50, 8'h41, 8'h54, 8'h43, 8'h48, 8'h00, 8'h00, 8'h00},  // PATCH
    '{8'h44, 8'h45, 8'h4C, 8'h45, 8'h54, 8'h45, 8'h00, 8'h00}   // DELETE
  };
  localparam logic [2:0] NameLen [NumMethods] = '{3'd3, 3'd4, 3'd3, 3'd5, 3'd6};

  // Protocol signature "HTTP".
  localparam logic [7:0] SigTab [4] = '{8'h48, 8'h54, 8'h54, 8'h50};

  // True for an ASCII decimal digit.
  function automatic logic is_digit(input logic [7:0] b);
    return (b >= CharZero) && (b <= CharNine);
  endfunction

endpackage

// ----- sv/hrlp_stream_if.sv -----
// Valid/ready stream channel for the HTTP request line parser.
// The payload type is set per instance; uses no package directly.
interface hrlp_stream_if #(
  parameter type item_t = logic
);
  logic  valid;
  logic  ready;
  item_t payload;

  modport source (output valid, output payload, input ready);
  modport sink (input valid, input payload, output ready);
endinterface

// ----- sv/http_request_line_parser_top.sv -----
// HTTP request line parser, top level. Depends on hrlp_pkg and hrlp_stream_if.
// A result is registered and appears in the cycle after the byte that causes it is taken.
// Throughput: one byte per cycle; the result register is the only stage, and
// a byte is taken whenever that register is empty or is being emptied.
// Reset (rst, synchronous, active high) returns the parser to the start of a
// line and empties the result register; the parser also restarts after each line.
module http_request_line_parser_top (
  input logic         clk,
  input logic         rst,
  hrlp_stream_if.sink bytes,
  hrlp_stream_if.source results
);
  import hrlp_pkg::*;

  // One-hot parse phases.
  typedef enum logic [9:0] {
    PhMethod = 10'b00_0000_0001,
    PhSeek   = 10'b00_0000_0010,
    PhSpace  = 10'b00_0000_0100,
    PhPath   = 10'b00_0000_1000,
    PhQuery  = 10'b00_0001_0000,
    PhSig    = 10'b00_0010_0000,
    PhVslash = 10'b00_0100_0000,
    PhMajor  = 10'b00_1000_0000,
    PhTail   = 10'b01_0000_0000,
    PhDrain  = 10'b10_0000_0000
  } phase_t;

  // Parser state.
  phase_t                  phase, phase_next;
  logic [NumMethods-1:0]   method_candidates, method_candidates_next;
  logic [2:0]              token_index, token_index_next;
  logic [3:0]              line_count, line_count_next;
  logic [2:0]              first_error, first_error_next;
  logic [2:0]              method_found, method_found_next;
  logic [3:0]              major_digit, major_digit_next;
  logic [3:0]              minor_digit, minor_digit_next;
  logic [1:0]              tail_count, tail_count_next;

  // Result register.
  out_item_t result, result_next;
  logic      result_valid;

  // Per-byte working signals.
  in_item_t              item;
  logic                  accept;
  logic                  emit;
  logic                  do_fail;
  logic [2:0]            fail_code;
  logic [NumMethods-1:0] keep;
  logic                  name_done;
  logic [2:0]            name_code;
  logic [2:0]            status;

  assign item         = bytes.payload;
  assign bytes.ready  = !result_valid || results.ready;
  assign accept       = bytes.valid && bytes.ready;
  assign results.valid   = result_valid;
  assign results.payload = result;

  // Method matching: drop candidates whose name differs at this position,
  // and note a name that ends here (lowest code wins).
  always_comb begin
    keep      = '0;
    name_done = 1'b0;
    name_code = MethodGet;
    for (int i = 0; i < NumMethods; i++) begin
      keep[i] = method_candidates[i] && (token_index < NameLen[i]) &&
                (NameTab[i][token_index] == item.data_byte);
    end
    for (int i = NumMethods - 1; i >= 0; i--) begin
      if (keep[i] && (NameLen[i] == token_index + 3'd1)) begin
        name_done = 1'b1;
        name_code = 3'(i);
      end
    end
  end

  // Next state for the accepted byte.
  always_comb begin
    phase_next             = phase;
    method_candidates_next = method_candidates;
    token_index_next       = token_index;
    first_error_next       = first_error;
    method_found_next      = method_found;
    major_digit_next       = major_digit;
    minor_digit_next       = minor_digit;
    tail_count_next        = tail_count;
    emit                   = 1'b0;
    do_fail                = 1'b0;
    fail_code              = StOk;
    line_count_next        = (line_count < MinLine) ? line_count + 4'd1 : line_count;

    unique case (phase)
      PhMethod: begin
        method_candidates_next = keep;
        if (keep == '0) begin
          do_fail   = 1'b1;
          fail_code = StBadMethod;
        end else if (name_done) begin
          method_found_next = name_code;
          phase_next        = PhSeek;
        end else begin
          token_index_next = token_index + 3'd1;
        end
      end
      PhSeek: begin
        if (item.data_byte == CharSpace) phase_next = PhSpace;
      end
      PhSpace: begin
        if (item.data_byte == CharSlash) begin
          emit       = 1'b1;
          phase_next = PhPath;
        end else begin
          do_fail   = 1'b1;
          fail_code = StBadPath;
        end
      end
      PhPath, PhQuery: begin
        if (item.data_byte == CharSpace) begin
          phase_next       = PhSig;
          token_index_next = '0;
        end else if (item.data_byte == CharQuestion) begin
          phase_next = PhQuery;
        end else if (phase == PhPath) begin
          emit = 1'b1;
        end
      end
      PhSig: begin
        if (token_index[2] || (item.data_byte != SigTab[token_index[1:0]])) begin
          do_fail   = 1'b1;
          fail_code = StBadSig;
        end else begin
          token_index_next = token_index + 3'd1;
          if (token_index[1:0] == 2'd3) phase_next = PhVslash;
        end
      end
      PhVslash: begin
        if (item.last_byte) begin
          do_fail   = 1'b1;
          fail_code = StTooShort;
        end else if (item.data_byte != CharSlash) begin
          do_fail   = 1'b1;
          fail_code = StBadSig;
        end else begin
          phase_next = PhMajor;
        end
      end
      PhMajor: begin
        if (!is_digit(item.data_byte)) begin
          do_fail   = 1'b1;
          fail_code = StBadVersion;
        end else begin
          major_digit_next = item.data_byte[3:0];
          phase_next       = PhTail;
          tail_count_next  = '0;
          token_index_next = '0;
        end
      end
      PhTail: begin
        // Bit 0 of the token index marks the dot, bit 1 the minor digit.
        if (tail_count != 2'd3) tail_count_next = tail_count + 2'd1;
        if ((tail_count_next == 2'd1) && (item.data_byte == CharDot)) begin
          token_index_next = token_index | 3'b001;
        end
        if ((tail_count_next == 2'd2) && is_digit(item.data_byte)) begin
          token_index_next = token_index | 3'b010;
          minor_digit_next = item.data_byte[3:0];
        end
      end
      PhDrain: begin
      end
      default: begin
      end
    endcase

    // The first error of the line is kept; parsing stops until the line ends.
    if (do_fail) begin
      if (first_error == StOk) first_error_next = fail_code;
      phase_next = PhDrain;
    end
  end

  // Final status of the line, from the state after this byte.
  always_comb begin
    if (line_count_next < MinLine) begin
      status = StTooShort;
    end else if (first_error_next != StOk) begin
      status = first_error_next;
    end else begin
      unique case (phase_next)
        PhMethod:                 status = StBadMethod;
        PhSeek:                   status = StNoSpace;
        PhSpace, PhPath, PhQuery: status = StBadPath;
        PhSig:                    status = StBadSig;
        PhTail: begin
          case (tail_count_next)
            2'd0:    status = StOk;
            2'd1:    status = StBadVersion;
            2'd2:    status = (token_index_next[1:0] == 2'b11) ? StOk : StBadVersion;
            default: status = StTooLong;
          endcase
        end
        default:                  status = StTooShort;
      endcase
    end
  end

  // Result payload: a path byte, or the status with the method and version.
  always_comb begin
    result_next = '0;
    if (item.last_byte) begin
      result_next.kind   = KindStatus;
      result_next.status = status;
      if (status == StOk) begin
        result_next.method_code   = method_found_next;
        result_next.version_major = major_digit_next;
        // With no bytes after the major digit the minor version reads zero.
        result_next.version_minor = (tail_count_next == 2'd0) ? 4'd0 : minor_digit_next;
      end
    end else begin
      result_next.kind      = KindPath;
      result_next.path_byte = item.data_byte;
    end
  end

  // Parser state registers; the end of a line restarts the parser.
  always_ff @(posedge clk) begin
    if (rst || (accept && item.last_byte)) begin
      phase             <= PhMethod;
      method_candidates <= '1;
      token_index       <= '0;
      line_count        <= '0;
      first_error       <= StOk;
      method_found      <= MethodGet;
      major_digit       <= '0;
      minor_digit       <= '0;
      tail_count        <= '0;
    end else if (accept) begin
      phase             <= phase_next;
      method_candidates <= method_candidates_next;
      token_index       <= token_index_next;
      line_count        <= line_count_next;
      first_error       <= first_error_next;
      method_found      <= method_found_next;
      major_digit       <= major_digit_next;
      minor_digit       <= minor_digit_next;
      tail_count        <= tail_count_next;
    end
  end

  // Result register: filled by a byte that gives a result, emptied by a transfer.
  always_ff @(posedge clk) begin
    if (rst) begin
      result_valid <= 1'b0;
    end else if (accept && (item.last_byte || emit)) begin
      result_valid <= 1'b1;
    end else if (results.ready) begin
      result_valid <= 1'b0;
    end
  end

  always_ff @(posedge clk) begin
    if (accept && (item.last_byte || emit)) begin
      result <= result_next;
    end
  end

endmodule
